FILE: rtl/core/htlp_pkg.sv
`default_nettype none

package htlp_pkg;

  localparam int TABLE_SLOTS_DEF = 32;
  localparam int KEY_BYTES_DEF   = 8;

  localparam int HASH_W     = 64;
  localparam int KEY_PORT_W = 64;
  localparam int LEN_W      = 4;
  localparam int VAL_W      = 32;
  localparam int SIDX_W     = 5;
  localparam int SLOT_ST_W  = 2;

  localparam logic [HASH_W-1:0] DJB2_START = 64'd5381;

  // hash is reduced two bits a step, msb first
  localparam int MOD_DIGITS = HASH_W / 2;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;

  localparam logic [SLOT_ST_W-1:0] SLOT_EMPTY   = 2'd0;
  localparam logic [SLOT_ST_W-1:0] SLOT_USED    = 2'd1;
  localparam logic [SLOT_ST_W-1:0] SLOT_DELETED = 2'd2;

  localparam logic [1:0] RES_OK        = 2'd0;
  localparam logic [1:0] RES_NOT_FOUND = 2'd1;
  localparam logic [1:0] RES_FULL      = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_MOD,
    ST_READ,
    ST_PROBE,
    ST_RESP
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/core/hash_table_linear_probe.sv
// channel  direction  handshake               payload
// in       input      in_valid / in_ready     in_cmd, in_key, in_key_len, in_entry_value
// out      output     out_valid / out_ready   out_status, out_found_value, out_slot_index
//
// one beat at a time: hashing does one multiply-add by 33 per key byte,
// then home slot reduction (none when TABLE_SLOTS is a power of two),
// then a slot memory read and a linear probe of at most TABLE_SLOTS slots,
// then a response state and a return to idle; an unused command goes straight to response.
// the response state stalls while the output register is full.
// after reset a clearing pass empties every slot; in_ready stays low.
// a finished result waits in the output register; the next beat is taken meanwhile.
`default_nettype none

module hash_table_linear_probe
  import htlp_pkg::*;
#(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
  parameter int KEY_BYTES   = KEY_BYTES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [1:0]            in_cmd,
  input  wire logic [KEY_PORT_W-1:0] in_key,
  input  wire logic [LEN_W-1:0]      in_key_len,
  input  wire logic [VAL_W-1:0]      in_entry_value,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [1:0]                 out_status,
  output logic [VAL_W-1:0]           out_found_value,
  output logic [SIDX_W-1:0]          out_slot_index
);

  localparam int  IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int  CNT_W = (IDX_W > 5) ? IDX_W : 5;
  localparam int  MW    = IDX_W + 2;
  localparam int  KEY_W = 8 * KEY_BYTES;
  localparam int  ROW_W = SLOT_ST_W + LEN_W + KEY_W + VAL_W;
  localparam bit  POW2  = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_SLOTS - 1);
  localparam logic [CNT_W-1:0] LAST_CNT  = CNT_W'(TABLE_SLOTS - 1);
  localparam logic [MW-1:0]    N1 = MW'(TABLE_SLOTS);
  localparam logic [MW-1:0]    N2 = MW'(2 * TABLE_SLOTS);

  state_t state_r, state_nxt;

  logic [ROW_W-1:0] mem [TABLE_SLOTS];
  logic [ROW_W-1:0] rd_q;
  logic [IDX_W-1:0] rd_addr;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  logic [ROW_W-1:0] mem_wd;

  logic [CNT_W-1:0]  cnt_r;
  logic [1:0]        cmd_r;
  logic [KEY_W-1:0]  key_r;
  logic [KEY_W-1:0]  hkey_r;
  logic [LEN_W-1:0]  len_r;
  logic [VAL_W-1:0]  val_r;
  logic [HASH_W-1:0] h_r;
  logic [IDX_W-1:0]  rem_r;
  logic [IDX_W-1:0]  slot_r;
  logic [1:0]        res_status_r;
  logic [VAL_W-1:0]  res_val_r;
  logic [IDX_W-1:0]  res_slot_r;
  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [VAL_W-1:0]  out_val_r;
  logic [SIDX_W-1:0] out_slot_r;

  logic [LEN_W-1:0]  len_sat;
  logic [KEY_W-1:0]  key_m;
  logic [HASH_W-1:0] h_step;
  logic [MW-1:0]     t0, t1, t2;
  logic [IDX_W-1:0]  home;
  logic [IDX_W-1:0]  slot_next;
  logic              accept;
  logic              out_free;

  logic [SLOT_ST_W-1:0] row_st;
  logic [LEN_W-1:0]     row_len;
  logic [KEY_W-1:0]     row_key;
  logic [VAL_W-1:0]     row_val;
  logic                 probe_done;
  logic [1:0]           probe_status;
  logic [VAL_W-1:0]     probe_val;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE);

  assign len_sat = (in_key_len > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES) : in_key_len;

  always_comb begin
    for (int b = 0; b < KEY_BYTES; b++) begin
      key_m[8*b +: 8] = (LEN_W'(b) < len_sat) ? in_key[8*b +: 8] : 8'd0;
    end
  end

  // shared multiply-add by 33 and reduction step
  assign h_step = (h_r << 5) + h_r + HASH_W'(hkey_r[7:0]);
  assign t0     = {rem_r, h_r[HASH_W-1 -: 2]};
  assign t1     = (t0 >= N2) ? t0 - N2 : t0;
  assign t2     = (t1 >= N1) ? t1 - N1 : t1;

  assign home      = POW2 ? h_r[IDX_W-1:0] : rem_r;
  assign slot_next = (slot_r == LAST_SLOT) ? '0 : slot_r + 1'b1;

  assign row_st  = rd_q[ROW_W-1 -: SLOT_ST_W];
  assign row_len = rd_q[VAL_W+KEY_W +: LEN_W];
  assign row_key = rd_q[VAL_W +: KEY_W];
  assign row_val = rd_q[VAL_W-1:0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (cnt_r == LAST_CNT) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_INSERT || in_cmd == CMD_LOOKUP || in_cmd == CMD_DELETE) begin
            state_nxt = ST_HASH;
          end else begin
            state_nxt = ST_RESP;
          end
        end
      end
      ST_HASH: begin
        if (cnt_r == '0) state_nxt = POW2 ? ST_READ : ST_MOD;
      end
      ST_MOD: begin
        if (cnt_r == '0) state_nxt = ST_READ;
      end
      ST_READ:  state_nxt = ST_PROBE;
      ST_PROBE: begin
        if (probe_done) state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    mem_we       = 1'b0;
    mem_wa       = slot_r;
    mem_wd       = '0;
    rd_addr      = slot_next;
    probe_done   = 1'b0;
    probe_status = RES_NOT_FOUND;
    probe_val    = '0;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = cnt_r[IDX_W-1:0];
      end
      ST_READ:  rd_addr = home;
      ST_PROBE: begin
        if (cmd_r == CMD_INSERT) begin
          if (row_st == SLOT_EMPTY || row_st == SLOT_DELETED) begin
            mem_we       = 1'b1;
            mem_wd       = {SLOT_USED, len_r, key_r, val_r};
            probe_done   = 1'b1;
            probe_status = RES_OK;
          end else if (cnt_r == LAST_CNT) begin
            probe_done   = 1'b1;
            probe_status = RES_FULL;
          end
        end else begin
          if (row_st == SLOT_EMPTY) begin
            probe_done = 1'b1;
          end else if (row_st != SLOT_DELETED && row_len == len_r && row_key == key_r) begin
            probe_done   = 1'b1;
            probe_status = RES_OK;
            probe_val    = row_val;
            if (cmd_r == CMD_DELETE) begin
              mem_we = 1'b1;
              mem_wd = {SLOT_DELETED, rd_q[ROW_W-SLOT_ST_W-1:0]};
            end
          end else if (cnt_r == LAST_CNT) begin
            probe_done = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_RESP && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLEAR: cnt_r <= cnt_r + 1'b1;
        ST_IDLE: begin
          if (accept) begin
            cmd_r        <= in_cmd;
            key_r        <= key_m;
            hkey_r       <= key_m;
            len_r        <= len_sat;
            val_r        <= in_entry_value;
            h_r          <= DJB2_START;
            rem_r        <= '0;
            cnt_r        <= CNT_W'(len_sat);
            res_status_r <= RES_NOT_FOUND;
            res_val_r    <= '0;
            res_slot_r   <= '0;
          end
        end
        ST_HASH: begin
          if (cnt_r == '0) begin
            cnt_r <= CNT_W'(MOD_DIGITS - 1);
          end else begin
            h_r    <= h_step;
            hkey_r <= hkey_r >> 8;
            cnt_r  <= cnt_r - 1'b1;
          end
        end
        ST_MOD: begin
          rem_r <= t2[IDX_W-1:0];
          h_r   <= h_r << 2;
          cnt_r <= cnt_r - 1'b1;
        end
        ST_READ: begin
          slot_r <= home;
          cnt_r  <= '0;
        end
        ST_PROBE: begin
          if (probe_done) begin
            res_status_r <= probe_status;
            res_val_r    <= probe_val;
            res_slot_r   <= (probe_status == RES_OK) ? slot_r : '0;
          end else begin
            slot_r <= slot_next;
            cnt_r  <= cnt_r + 1'b1;
          end
        end
        ST_RESP: begin
          if (out_free) begin
            out_status_r <= res_status_r;
            out_val_r    <= res_val_r;
            out_slot_r   <= SIDX_W'(res_slot_r);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_value = out_val_r;
  assign out_slot_index  = out_slot_r;

`ifndef ASSERT_OFF
  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_CLEAR || state_r == ST_PROBE))
    else $error("slot memory written outside clear or probe");

  a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PROBE |-> (cnt_r <= LAST_CNT && slot_r <= LAST_SLOT))
    else $error("probe ran past the table");

  a_full_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESP && res_status_r == RES_FULL) |-> cmd_r == CMD_INSERT)
    else $error("table full reported for a non-insert command");
`endif

endmodule

`default_nettype wire
